>>> design/assert_macros.svh
// Assertion macros used by the hash index controller.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> design/pbhi_pkg.sv
// Package for the page buffer hash index: sizes, codes, command/status types.
// No dependencies.
package pbhi_pkg;
    localparam int BUCKET_COUNT_DEF = 1024;
    localparam int SLOT_COUNT_DEF   = 1024;
    localparam int TABLE_COUNT_DEF  = 2;
    localparam int PTR_W = 11;
    localparam logic [PTR_W-1:0] NIL_SLOT = 11'h7FF;
    localparam int KEY_W = 48;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic latch;       // capture request
        logic head_rd;     // read bucket head
        logic head_take;   // cur <- head data, steps <- 0
        logic node_rd;     // read key/link of cur
        logic node_adv;    // prev <- cur, cur <- link, steps++
        logic ins_wr;      // write key, link, head
        logic del_head_wr; // head <- link of hit
        logic del_link_wr; // link[prev] <- link of hit
        logic clr_start;   // clear counter <- 0
        logic clr_wr;      // clear one bucket, advance
        logic set_status;  // load result
        logic [1:0] status;
        logic found_ok;    // found_slot <- cur
    } pbhi_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic slot_bad;
        logic cur_end;     // cur nil, out of range or step bound reached
        logic key_hit;
        logic prev_nil;
        logic clr_last;
    } pbhi_sts_t;
endpackage

>>> design/pbhi_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pbhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> design/pbhi_datapath.sv
// Datapath of the hash index: request registers, three RAMs, chain walk pointers.
// Depends on pbhi_pkg and pbhi_ram.
module pbhi_datapath #(
    parameter int BUCKET_COUNT = pbhi_pkg::BUCKET_COUNT_DEF,
    parameter int SLOT_COUNT   = pbhi_pkg::SLOT_COUNT_DEF,
    parameter int TABLE_COUNT  = pbhi_pkg::TABLE_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [60:0]         req_data,
    input  pbhi_pkg::pbhi_cmd_t cmd,
    output pbhi_pkg::pbhi_sts_t sts,
    output logic [15:0]         res_data
);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int TW = (TABLE_COUNT > 1) ? 1 : 0;
    localparam int HD = TABLE_COUNT * (1 << BW);
    localparam int ND = TABLE_COUNT * (1 << SW);
    localparam int HAW = $clog2(HD);
    localparam int NAW = $clog2(ND);
    localparam int PW = pbhi_pkg::PTR_W;
    localparam int KW = pbhi_pkg::KEY_W;

    logic [1:0]  action_reg;
    logic        table_reg;
    logic [KW-1:0] key_reg;
    logic [9:0]  slot_reg;
    logic [BW-1:0] bucket_reg;
    logic [PW-1:0] cur_reg, prev_reg;
    logic [SW:0] steps_reg;
    logic [HAW-1:0] clr_reg;
    logic [1:0]  status_reg;
    logic [9:0]  found_reg;

    logic [32:0] sum;
    logic [BW-1:0] bucket_next;
    assign sum = {17'd0, req_data[18:3]} + {1'b0, req_data[50:19]};
    // bucket = sum mod BUCKET_COUNT; the bucket count is a power of two, so keep the low bits
    assign bucket_next = sum[BW-1:0];

    logic          tsel;
    logic [HAW-1:0] head_addr;
    logic [NAW-1:0] node_addr;
    logic           head_we, node_we, key_we;
    logic [PW-1:0]  head_wdata, head_rdata, link_wdata, link_rdata;
    logic [KW-1:0]  key_rdata;

    assign tsel = (TW == 1) ? table_reg : 1'b0;

    always_comb
    begin
        if (TW == 1)
            head_addr = HAW'({tsel, bucket_reg});
        else
            head_addr = HAW'(bucket_reg);
        if (cmd.clr_wr)
            head_addr = clr_reg;
        head_we = cmd.ins_wr | cmd.del_head_wr | cmd.clr_wr;
        if (cmd.clr_wr)
            head_wdata = pbhi_pkg::NIL_SLOT;
        else if (cmd.ins_wr)
            head_wdata = {1'b0, slot_reg};
        else
            head_wdata = link_rdata;
    end

    logic [SW-1:0] node_slot;
    always_comb
    begin
        if (cmd.ins_wr)
            node_slot = slot_reg[SW-1:0];
        else if (cmd.del_link_wr)
            node_slot = prev_reg[SW-1:0];
        else
            node_slot = cur_reg[SW-1:0];
        if (TW == 1)
            node_addr = NAW'({tsel, node_slot});
        else
            node_addr = NAW'(node_slot);
        node_we = cmd.ins_wr | cmd.del_link_wr;
        key_we  = cmd.ins_wr;
        link_wdata = cmd.ins_wr ? head_rdata : link_rdata;
    end

    pbhi_ram #(.WIDTH(PW), .DEPTH(HD)) u_heads (
        .clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wdata), .rdata(head_rdata));
    pbhi_ram #(.WIDTH(PW), .DEPTH(ND)) u_links (
        .clk(clk), .we(node_we), .addr(node_addr), .wdata(link_wdata), .rdata(link_rdata));
    pbhi_ram #(.WIDTH(KW), .DEPTH(ND)) u_keys (
        .clk(clk), .we(key_we), .addr(node_addr), .wdata(key_reg), .rdata(key_rdata));

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= req_data[1:0];
            table_reg  <= req_data[2];
            key_reg    <= {req_data[18:3], req_data[50:19]};
            slot_reg   <= req_data[60:51];
            bucket_reg <= bucket_next;
        end
        if (cmd.head_take)
        begin
            cur_reg   <= head_rdata;
            prev_reg  <= pbhi_pkg::NIL_SLOT;
            steps_reg <= '0;
        end
        else if (cmd.node_adv)
        begin
            prev_reg  <= cur_reg;
            cur_reg   <= link_rdata;
            steps_reg <= steps_reg + 1'b1;
        end
    end

    // clear counter starts at zero so the pass after reset sweeps every bucket head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_start)
            clr_reg <= '0;
        else if (cmd.clr_wr)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= pbhi_pkg::ST_OK;
            found_reg  <= '0;
        end
        else if (cmd.set_status)
        begin
            status_reg <= cmd.status;
            found_reg  <= cmd.found_ok ? cur_reg[9:0] : 10'd0;
        end
    end

    assign sts.action   = action_reg;
    assign sts.slot_bad = ({1'b0, slot_reg} >= 11'(SLOT_COUNT));
    assign sts.cur_end  = (cur_reg == pbhi_pkg::NIL_SLOT) || (cur_reg >= PW'(SLOT_COUNT))
                          || (steps_reg >= (SW+1)'(SLOT_COUNT));
    assign sts.key_hit  = (key_rdata == key_reg);
    assign sts.prev_nil = (prev_reg == pbhi_pkg::NIL_SLOT);
    assign sts.clr_last = (clr_reg == HAW'(HD - 1));
    assign res_data = {4'd0, found_reg, status_reg};
endmodule

>>> design/pbhi_ctrl.sv
// Controller state machine of the hash index: sequences reads, chain walk and writes.
// Depends on pbhi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pbhi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  pbhi_pkg::pbhi_sts_t sts,
    output pbhi_pkg::pbhi_cmd_t cmd
);
    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_HEAD  = 10'b0000000100,
        S_HWAIT = 10'b0000001000,
        S_CHECK = 10'b0000010000,
        S_NWAIT = 10'b0000100000,
        S_TEST  = 10'b0001000000,
        S_DEL   = 10'b0010000000,
        S_CLR   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // a new request is taken only in idle with the result slot free
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        cmd            = '0;
        unique case (state_reg)
            S_INIT:
            begin
                // empty every bucket head after reset, no response
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (sts.action == pbhi_pkg::ACT_CLEAR)
                begin
                    cmd.clr_start = 1'b1;
                    state_next    = S_CLR;
                end
                else if (sts.action == pbhi_pkg::ACT_INSERT && sts.slot_bad)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pbhi_pkg::ST_RANGE;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_HWAIT;
                end
            end
            S_HWAIT:
            begin
                if (sts.action == pbhi_pkg::ACT_INSERT)
                begin
                    cmd.ins_wr     = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = pbhi_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.head_take = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.cur_end)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pbhi_pkg::ST_NOTFOUND;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_NWAIT;
                end
            end
            S_NWAIT:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (!sts.key_hit)
                begin
                    cmd.node_adv = 1'b1;
                    state_next   = S_CHECK;
                end
                else if (sts.action == pbhi_pkg::ACT_LOOKUP)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pbhi_pkg::ST_OK;
                    cmd.found_ok   = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_DEL;
                end
            end
            S_DEL:
            begin
                // link of the hit is still on the link RAM output
                cmd.del_head_wr = sts.prev_nil;
                cmd.del_link_wr = !sts.prev_nil;
                cmd.set_status  = 1'b1;
                cmd.status      = pbhi_pkg::ST_OK;
                state_next      = S_DONE;
            end
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = pbhi_pkg::ST_OK;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, s_tready, state_reg == S_IDLE)
    `ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, m_tvalid)
    `ASSERT_IMPLIES(a_one_write, clk, rst_n, 1'b1,
        $countones({cmd.ins_wr, cmd.del_head_wr, cmd.del_link_wr, cmd.clr_wr}) <= 1)
endmodule

>>> design/page_buffer_hash_index.sv
// Page buffer hash index: chained hash table, key (volume, page) -> buffer slot.
// Insert links the new slot in at the bucket head (an out-of-range slot gets ST_RANGE), lookup
// and delete walk the chain entry by entry, and clear-all empties every bucket head in turn.
// One request at a time; the chain walk sets the rate.
// Reset (rst_n low, async) clears control, then a pass over all TABLE_COUNT*BUCKET_COUNT
// heads empties them while s_tready stays low. BUCKET_COUNT must be a power of two (unchecked).
module page_buffer_hash_index #(
    parameter int BUCKET_COUNT = pbhi_pkg::BUCKET_COUNT_DEF,
    parameter int SLOT_COUNT   = pbhi_pkg::SLOT_COUNT_DEF,
    parameter int TABLE_COUNT  = pbhi_pkg::TABLE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], buffer_type[2], volume_number[18:3], page_number[50:19],
    // slot_index[60:51], zero fill [63:61]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[1:0], found_slot[11:2], zero fill [15:12]
    output logic [15:0] m_tdata
);
    pbhi_pkg::pbhi_cmd_t cmd;
    pbhi_pkg::pbhi_sts_t sts;

    pbhi_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .sts(sts), .cmd(cmd));

    pbhi_datapath #(
        .BUCKET_COUNT(BUCKET_COUNT), .SLOT_COUNT(SLOT_COUNT), .TABLE_COUNT(TABLE_COUNT)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .req_data(s_tdata[60:0]), .cmd(cmd), .sts(sts),
        .res_data(m_tdata));
endmodule

>>> tb/tb_page_buffer_hash_index.sv
// Self-checking testbench for the page buffer hash index: holds its own model of
// the chained tables and checks every response against it.
// Depends on pbhi_pkg and page_buffer_hash_index.
`timescale 1ns / 100ps

module tb_page_buffer_hash_index;
    localparam int BUCKETS = pbhi_pkg::BUCKET_COUNT_DEF;
    localparam int SLOTS   = pbhi_pkg::SLOT_COUNT_DEF;
    localparam int TABLES  = pbhi_pkg::TABLE_COUNT_DEF;
    localparam int N_RANDOM = 1830;
    localparam int CYCLE_LIMIT = 25000000;

    // Mirror of both hash tables; predicts the response of each request.
    class hash_index_scoreboard;
        logic [pbhi_pkg::PTR_W-1:0] heads[TABLES*BUCKETS];
        logic [pbhi_pkg::PTR_W-1:0] links[TABLES*SLOTS];
        logic [pbhi_pkg::KEY_W-1:0] keys[TABLES*SLOTS];
        logic [11:0]      expected_q[$];
        int               mismatches;
        int               checked;
        int               action_cnt[4];

        function new();
            foreach (heads[i]) heads[i] = pbhi_pkg::NIL_SLOT;
            foreach (links[i]) links[i] = '0;
            foreach (keys[i]) keys[i] = '0;
            mismatches = 0;
            checked = 0;
            foreach (action_cnt[i]) action_cnt[i] = 0;
        endfunction

        // Walk one chain; give the first matching slot and its predecessor.
        function int find_slot(int tbl, int bkt, logic [pbhi_pkg::KEY_W-1:0] key,
                               output int prev);
            int cur;
            int prv;
            int steps;
            cur = heads[tbl*BUCKETS + bkt];
            prv = pbhi_pkg::NIL_SLOT;
            steps = 0;
            prev = pbhi_pkg::NIL_SLOT;
            while (cur != pbhi_pkg::NIL_SLOT && cur < SLOTS && steps < SLOTS)
            begin
                if (keys[tbl*SLOTS + cur] == key)
                begin
                    prev = prv;
                    return cur;
                end
                prv = cur;
                cur = links[tbl*SLOTS + cur];
                steps++;
            end
            return pbhi_pkg::NIL_SLOT;
        endfunction

        function void note_request(logic [63:0] req);
            logic [1:0]       act;
            int               tbl;
            logic [15:0]      vol;
            logic [31:0]      page;
            int               slot;
            logic [pbhi_pkg::KEY_W-1:0] key;
            logic [32:0]      sum;
            int               bkt;
            int               hit;
            int               prev;
            logic [1:0]       status;
            logic [9:0]       found;
            act  = req[1:0];
            tbl  = int'(req[2]) % TABLES;
            vol  = req[18:3];
            page = req[50:19];
            slot = req[60:51];
            key  = {vol, page};
            sum  = {17'd0, vol} + {1'b0, page};
            bkt  = int'(sum % BUCKETS);
            status = pbhi_pkg::ST_OK;
            found  = '0;
            action_cnt[act]++;
            case (act)
                pbhi_pkg::ACT_LOOKUP:
                begin
                    hit = find_slot(tbl, bkt, key, prev);
                    if (hit == pbhi_pkg::NIL_SLOT)
                        status = pbhi_pkg::ST_NOTFOUND;
                    else
                        found = hit[9:0];
                end
                pbhi_pkg::ACT_INSERT:
                begin
                    if (slot >= SLOTS)
                        status = pbhi_pkg::ST_RANGE;
                    else
                    begin
                        keys[tbl*SLOTS + slot]  = key;
                        links[tbl*SLOTS + slot] = heads[tbl*BUCKETS + bkt];
                        heads[tbl*BUCKETS + bkt] = slot[pbhi_pkg::PTR_W-1:0];
                    end
                end
                pbhi_pkg::ACT_DELETE:
                begin
                    hit = find_slot(tbl, bkt, key, prev);
                    if (hit == pbhi_pkg::NIL_SLOT)
                        status = pbhi_pkg::ST_NOTFOUND;
                    else if (prev == pbhi_pkg::NIL_SLOT)
                        heads[tbl*BUCKETS + bkt] = links[tbl*SLOTS + hit];
                    else
                        links[tbl*SLOTS + prev] = links[tbl*SLOTS + hit];
                end
                default:
                    foreach (heads[i]) heads[i] = pbhi_pkg::NIL_SLOT;
            endcase
            expected_q.push_back({found, status});
        endfunction

        function void check_response(logic [15:0] rsp);
            logic [11:0] exp_rsp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response %h with no request outstanding", rsp);
                return;
            end
            exp_rsp = expected_q.pop_front();
            checked++;
            if (rsp[1:0] !== exp_rsp[1:0] || rsp[11:2] !== exp_rsp[11:2] || rsp[15:12] !== 4'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status exp %0d got %0d, found_slot exp %0d got %0d",
                             exp_rsp[1:0], rsp[1:0], exp_rsp[11:2], rsp[11:2]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // action, buffer_type, volume_number, page_number, slot_index
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // status, found_slot

    hash_index_scoreboard sb;
    int          cycle_cnt;
    logic [15:0] vol_pool[16];
    logic [31:0] page_pool[16];

    page_buffer_hash_index u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Record each accepted request and check each accepted response. Both blocks
    // see values from before the edge since everything updates with NBAs.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_response(m_tdata);
    end

    // Receiver backpressure: alternate quiet stretches with random stalls.
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 400;
            if (stall_phase < 120)
                m_tready <= 1'b1;
            else if (stall_phase < 260)
                m_tready <= ($urandom_range(0, 2) != 0);
            else
                m_tready <= ($urandom_range(0, 4) == 0);
        end
    end

    // Hard stop if the block hangs.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    // Hold one request on the bus until the block takes it.
    task automatic send_request(logic [1:0] act, logic bt, logic [15:0] vol,
                                logic [31:0] page, logic [9:0] slot);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, slot, page, vol, bt, act};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic idle_cycles(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        idle_cycles(1);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Pick a key: mostly from a small pool so chains collide and hit,
    // now and then a fully random one.
    task automatic pick_key(output logic [15:0] vol, output logic [31:0] page);
        if ($urandom_range(0, 9) < 8)
        begin
            vol  = vol_pool[$urandom_range(0, 15)];
            page = page_pool[$urandom_range(0, 15)];
        end
        else
        begin
            vol  = 16'($urandom);
            page = $urandom;
        end
    endtask

    task automatic random_request();
        logic [15:0] vol;
        logic [31:0] page;
        logic [9:0]  slot;
        logic        bt;
        int          pick;
        pick_key(vol, page);
        slot = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 47)) : 10'($urandom);
        bt   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 199);
        if (pick < 70)
            send_request(pbhi_pkg::ACT_INSERT, bt, vol, page, slot);
        else if (pick < 140)
            send_request(pbhi_pkg::ACT_LOOKUP, bt, vol, page, slot);
        else if (pick < 199)
            send_request(pbhi_pkg::ACT_DELETE, bt, vol, page, slot);
        else
            send_request(pbhi_pkg::ACT_CLEAR, bt, vol, page, slot);
    endtask

    initial
    begin
        int burst;
        int sent;
        sb = new();
        cycle_cnt = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        // Pool: extremes, randoms, and pages that share a bucket.
        vol_pool[0] = 16'h0000;
        vol_pool[1] = 16'hFFFF;
        page_pool[0] = 32'h0000_0000;
        page_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++)
        begin
            vol_pool[i]  = (i < 8) ? 16'(i) : 16'($urandom);
            page_pool[i] = (i < 9) ? 32'(i * BUCKETS) : $urandom;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Right after reset every bucket is empty in both tables.
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b0, 16'h0, 32'h0, 10'd0);
        // Directed: extreme keys, both tables, duplicates, relinked slot.
        send_request(pbhi_pkg::ACT_INSERT, 1'b0, 16'h0000, 32'h0000_0000, 10'd0);
        send_request(pbhi_pkg::ACT_INSERT, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b0, 16'h0000, 32'h0000_0000, 10'd0);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 10'd0);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b0, 16'hFFFF, 32'hFFFF_FFFF, 10'd0);
        send_request(pbhi_pkg::ACT_INSERT, 1'b0, 16'h0001, 32'h0000_03FF, 10'd5);
        send_request(pbhi_pkg::ACT_INSERT, 1'b0, 16'h0000, 32'h0000_0400, 10'd6);
        send_request(pbhi_pkg::ACT_INSERT, 1'b0, 16'h0001, 32'h0000_03FF, 10'd7);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b0, 16'h0001, 32'h0000_03FF, 10'd0);
        send_request(pbhi_pkg::ACT_DELETE, 1'b0, 16'h0000, 32'h0000_0400, 10'd0);
        send_request(pbhi_pkg::ACT_DELETE, 1'b0, 16'h0001, 32'h0000_03FF, 10'd0);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b0, 16'h0001, 32'h0000_03FF, 10'd0);
        send_request(pbhi_pkg::ACT_DELETE, 1'b0, 16'h0001, 32'h0000_03FF, 10'd0);
        send_request(pbhi_pkg::ACT_DELETE, 1'b0, 16'h0001, 32'h0000_03FF, 10'd0);
        // Insert a slot twice into one bucket: the chain loops on itself.
        send_request(pbhi_pkg::ACT_INSERT, 1'b1, 16'h0002, 32'h0000_0000, 10'd9);
        send_request(pbhi_pkg::ACT_INSERT, 1'b1, 16'h0001, 32'h0000_0001, 10'd9);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b1, 16'h0000, 32'h0000_0002, 10'd0);
        send_request(pbhi_pkg::ACT_DELETE, 1'b1, 16'h0000, 32'h0000_0002, 10'd0);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b1, 16'h0001, 32'h0000_0001, 10'd0);
        send_request(pbhi_pkg::ACT_CLEAR, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF);
        send_request(pbhi_pkg::ACT_LOOKUP, 1'b0, 16'h0000, 32'h0000_0000, 10'd0);
        drain();

        // Random part in bursts with gaps.
        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < N_RANDOM; k++)
            begin
                random_request();
                sent++;
            end
            if (sent > N_RANDOM / 2 && sent - burst <= N_RANDOM / 2)
                drain();
            idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
        end
        drain();
        repeat (50) @(posedge clk);

        $display("covered %0d lookups, %0d inserts, %0d deletes, %0d clears",
                 sb.action_cnt[pbhi_pkg::ACT_LOOKUP], sb.action_cnt[pbhi_pkg::ACT_INSERT],
                 sb.action_cnt[pbhi_pkg::ACT_DELETE], sb.action_cnt[pbhi_pkg::ACT_CLEAR]);
        $display("%0d responses checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+design
design/pbhi_pkg.sv
design/pbhi_ram.sv
design/pbhi_datapath.sv
design/pbhi_ctrl.sv
design/page_buffer_hash_index.sv
tb/tb_page_buffer_hash_index.sv
